### hw/rtl/rth_pkg.sv
// shared types, widths and the squared cosine table for the rgb to hsi core
package rth_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned SumW    = 10;
  localparam int unsigned SqW     = 18;
  localparam int unsigned NumW    = 18;
  localparam int unsigned TabFrac = 44;
  localparam int unsigned TabW    = TabFrac + 1;
  localparam int unsigned ProdW   = SqW + TabW;
  localparam int unsigned SearchSteps = 8;
  localparam int unsigned MaxDeg  = 180;
  localparam int unsigned QuarterDeg = 90;
  localparam int unsigned FullDeg = 360;

  typedef logic [TabW-1:0] rth_tab_t [0:QuarterDeg];

  // one item in flight through the search stages
  typedef struct packed {
    logic              special;   // dark or grey pixel
    logic              gge;       // green >= blue
    logic              npos;      // numerator of the cosine positive
    logic              nneg;      // numerator of the cosine negative
    logic [SqW-1:0]    n2;
    logic [SqW-1:0]    q4;
    logic [ChanW-1:0]  hue_n;     // degree count found so far
    logic [SumW-1:0]   sum;
    logic [NumW-1:0]   rem;       // saturation division remainder
    logic [ChanW-1:0]  quo;
    logic [ChanW-1:0]  inten;
  } rth_stage_t;

  // truncated q2.62 product
  function automatic logic [63:0] rth_mulq(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[125:62];
  endfunction

  // unsigned quotient by shift and subtract, table build only
  function automatic logic [63:0] rth_udiv(logic [63:0] a, logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] rth_pi_q62();
    logic [63:0] dec;
    logic [63:0] rem;
    logic [63:0] q;
    dec = 64'd1000000000000000000;
    rem = 64'd141592653589793238;
    q   = 64'd3;
    for (int i = 0; i < 62; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= dec) begin
        rem  = rem - dec;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // one degree in q2.62, truncated
  localparam logic [63:0] DegQ62 = rth_pi_q62() / 64'd180;

  function automatic logic [63:0] rth_series(logic [63:0] x, logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] d;
    x2   = rth_mulq(x, x);
    term = odd ? x : (64'd1 << 62);
    acc  = term;
    for (int n = 1; n <= 12; n++) begin
      d    = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = rth_udiv(rth_mulq(term, x2), d);
      if (n[0]) acc = acc - term;
      else      acc = acc + term;
    end
    return acc;
  endfunction

  function automatic rth_tab_t rth_build_tab();
    rth_tab_t    t;
    logic [63:0] v;
    logic [63:0] sq;
    for (int m = 0; m <= QuarterDeg; m++) begin
      if (m <= 45) v = rth_series(DegQ62 * 64'(m), 1'b0);
      else         v = rth_series(DegQ62 * 64'(QuarterDeg - m), 1'b1);
      sq   = rth_mulq(v, v);
      sq   = (sq + (64'd1 << (61 - TabFrac))) >> (62 - TabFrac);
      t[m] = sq[TabW-1:0];
    end
    return t;
  endfunction

  localparam rth_tab_t Cos2Tab = rth_build_tab();

endpackage

### hw/rtl/rgb_to_hsi_pixel_core.sv
// top level of the rgb to hsi pixel converter
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------------
//  in      | in_valid_i, in_stall_o | red_i, green_i, blue_i
//  out     | out_valid_o,out_stall_i| hue_half_degrees_o, saturation_level_o,
//          |                        | intensity_level_o
//
// one item per cycle while the output is not stalled: a front stage, eight search stages, an output stage
// each search stage settles one bit of the hue degree count (one 18 x 45 multiply against
// the squared cosine table) and one bit of the saturation quotient
// reset clears all valid bits; payload registers are not reset
// a stalled output freezes the whole pipe; in_stall_o follows it in the same cycle
module rgb_to_hsi_pixel_core import rth_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ChanW-1:0] hue_half_degrees_o,
  output logic [ChanW-1:0] saturation_level_o,
  output logic [ChanW-1:0] intensity_level_o
);

  logic en;

  // pipe moves unless a finished item is held at the output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // front stage: sums, min, intensity, saturation remainder, cosine numerator and denominator terms
  logic [SumW-1:0]       sum, diff;
  logic [ChanW-1:0]      mn;
  logic signed [10:0]    n_s;
  logic signed [8:0]     da, db, dgb;
  logic signed [21:0]    n2_s, q_s;
  logic [19:0]           inten_p;
  rth_stage_t            front_d, front_q;
  logic                  front_vq;

  always_comb begin
    sum  = SumW'(red_i) + SumW'(green_i) + SumW'(blue_i);
    mn   = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn) mn = blue_i;
    diff = sum - SumW'(3 * mn);
    n_s  = signed'({2'b00, red_i, 1'b0}) - signed'({3'b000, green_i})
         - signed'({3'b000, blue_i});
    da   = signed'({1'b0, red_i}) - signed'({1'b0, green_i});
    db   = signed'({1'b0, red_i}) - signed'({1'b0, blue_i});
    dgb  = signed'({1'b0, green_i}) - signed'({1'b0, blue_i});
    n2_s = 22'(n_s * n_s);
    // (r-g)^2 + (r-b)(g-b), never negative
    q_s  = 22'(da * da) + 22'(db * dgb);
    // floor(sum / 3) by reciprocal, exact over 0..765
    inten_p = 20'(sum) * 20'd683;

    front_d.inten   = inten_p[18:11];
    front_d.special = (sum < SumW'(3)) || (red_i == green_i && green_i == blue_i);
    front_d.gge     = (green_i >= blue_i);
    front_d.npos    = (n_s > 0);
    front_d.nneg    = (n_s < 0);
    front_d.n2      = n2_s[SqW-1:0];
    front_d.q4      = SqW'({q_s[15:0], 2'b00});
    front_d.hue_n   = '0;
    front_d.sum     = sum;
    front_d.rem     = NumW'({diff, 8'b0}) - NumW'(diff);
    front_d.quo     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_vq <= 1'b0;
    end else if (en) begin
      front_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      front_q <= front_d;
    end
  end

  // binary search over degrees, msb first, with restoring division alongside
  logic       vld [0:SearchSteps];
  rth_stage_t stg [0:SearchSteps];

  assign vld[0] = front_vq;
  assign stg[0] = front_q;

  for (genvar s = 0; s < SearchSteps; s++) begin : g_search
    rth_search_stage #(
      .Bit(SearchSteps - 1 - s)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(vld[s]),
      .data_i (stg[s]),
      .valid_o(vld[s+1]),
      .data_o (stg[s+1])
    );
  end

  // output stage: mirror the hue for green below blue, halve, mask special pixels
  rth_stage_t       last;
  logic [8:0]       deg;
  logic [ChanW-1:0] hue_d, sat_d;
  logic             out_vq;
  logic [ChanW-1:0] hue_q, sat_q, inten_q;

  always_comb begin
    last  = stg[SearchSteps];
    deg   = last.gge ? 9'(last.hue_n) : 9'(FullDeg) - 9'(last.hue_n);
    hue_d = last.special ? '0 : deg[8:1];
    sat_d = last.special ? '0 : last.quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (en) begin
      out_vq <= vld[SearchSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      inten_q <= last.inten;
    end
  end

  assign out_valid_o        = out_vq;
  assign hue_half_degrees_o = hue_q;
  assign saturation_level_o = sat_q;
  assign intensity_level_o  = inten_q;

  // hue never leaves the half degree range
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hue_half_degrees_o <= ChanW'(MaxDeg - 1))
    else $error("hue out of range");

  // a dark pixel carries no hue and no saturation
  a_dark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && intensity_level_o == '0) |->
      (hue_half_degrees_o == '0 && saturation_level_o == '0))
    else $error("dark pixel with hue or saturation");

  // input is held off only while a result waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

endmodule

### hw/rtl/rth_search_stage.sv
// one search stage: one hue bit by cosine compare, one saturation quotient bit
module rth_search_stage import rth_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  rth_stage_t data_i,
  output logic       valid_o,
  output rth_stage_t data_o
);

  logic             valid_q;
  rth_stage_t       data_q, data_d;
  logic [ChanW-1:0] t, k;
  logic [6:0]       idx;
  logic             in_range, sk_pos, sk_zero, lt, eq, pred;
  logic [1:0]       sn, sk;
  logic [ProdW-1:0] prod, m2;
  logic [NumW-1:0]  dvs;

  always_comb begin
    t        = data_i.hue_n | ChanW'(1 << Bit);
    in_range = (t <= ChanW'(MaxDeg));
    k        = data_i.gge ? t : t - ChanW'(1);
    sk_pos   = (k < ChanW'(QuarterDeg));
    sk_zero  = (k == ChanW'(QuarterDeg));
    idx      = (k <= ChanW'(QuarterDeg)) ? k[6:0] : 7'(ChanW'(MaxDeg) - k);
    prod     = ProdW'(data_i.q4) * ProdW'(Cos2Tab[idx]);
    m2       = ProdW'({data_i.n2, {TabFrac{1'b0}}});
    // sign codes: 2 positive, 1 zero, 0 negative
    sn = data_i.npos ? 2'd2 : (data_i.nneg ? 2'd0 : 2'd1);
    sk = sk_pos ? 2'd2 : (sk_zero ? 2'd1 : 2'd0);
    lt = 1'b0;
    eq = 1'b0;
    if (sn != sk) begin
      lt = (sn < sk);
    end else if (sn == 2'd1) begin
      eq = 1'b1;
    end else if (sn == 2'd2) begin
      lt = (m2 < prod);
      eq = (m2 == prod);
    end else begin
      lt = (m2 > prod);
      eq = (m2 == prod);
    end
    pred = data_i.gge ? (lt | eq) : lt;

    dvs    = NumW'(data_i.sum) << Bit;
    data_d = data_i;
    if (in_range && pred) data_d.hue_n = t;
    if (data_i.rem >= dvs) begin
      data_d.rem      = data_i.rem - dvs;
      data_d.quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### tb/testbench.sv
// self-checking testbench for the rgb to hsi pixel converter core
module testbench import rth_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency   = 10;
  localparam int unsigned IdleLimit = 2000;

  // one expected converted pixel
  typedef struct packed {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] inten;
  } hsi_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [ChanW-1:0] red_i;
  logic [ChanW-1:0] green_i;
  logic [ChanW-1:0] blue_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [ChanW-1:0] hue_half_degrees_o;
  logic [ChanW-1:0] saturation_level_o;
  logic [ChanW-1:0] intensity_level_o;

  rgb_to_hsi_pixel_core dut (.*);

  // squared cosines of 0..90 degrees, q0.44, built by our own q2.62 series
  logic [63:0] cos_sq [0:90];
  hsi_t        pending_hsi [$];
  int          mismatches;
  int          idle_cycles;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          timed_out;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return full[125:62];
  endfunction

  function automatic logic [63:0] taylor_q62(logic [63:0] x, bit odd);
    logic [63:0] xx;
    logic [63:0] term;
    logic [63:0] acc;
    xx   = mul_q62(x, x);
    term = odd ? x : 64'h4000_0000_0000_0000;
    acc  = term;
    for (int n = 1; n <= 12; n++) begin
      term = mul_q62(term, xx) / (odd ? 64'((2*n) * (2*n+1)) : 64'((2*n-1) * (2*n)));
      acc  = (n % 2 == 1) ? acc - term : acc + term;
    end
    return acc;
  endfunction

  initial begin : build_cos_sq
    logic [63:0] frac;
    logic [63:0] pi_val;
    logic [63:0] one_deg;
    logic [63:0] c;
    logic [63:0] sq;
    frac   = 64'd141592653589793238;
    pi_val = 64'd3;
    for (int i = 0; i < 62; i++) begin
      frac   = frac << 1;
      pi_val = pi_val << 1;
      if (frac >= 64'd1000000000000000000) begin
        frac      = frac - 64'd1000000000000000000;
        pi_val[0] = 1'b1;
      end
    end
    one_deg = pi_val / 64'd180;
    for (int m = 0; m <= 90; m++) begin
      c  = (m <= 45) ? taylor_q62(one_deg * 64'(m), 1'b0)
                     : taylor_q62(one_deg * 64'(90 - m), 1'b1);
      sq = mul_q62(c, c);
      cos_sq[m] = (sq + (64'd1 << 17)) >> 18;
    end
  end

  // sign of (pixel cosine - cos k degrees)
  function automatic int cos_order(int num, logic [63:0] num2, logic [63:0] den4, int k);
    int          sk;
    int          sn;
    logic [63:0] p;
    int          mc;
    sk = (k < 90) ? 1 : ((k == 90) ? 0 : -1);
    sn = (num > 0) ? 1 : ((num < 0) ? -1 : 0);
    if (sn != sk) return (sn > sk) ? 1 : -1;
    if (sn == 0) return 0;
    p  = den4 * cos_sq[(k <= 90) ? k : 180 - k];
    mc = (num2 > p) ? 1 : ((num2 < p) ? -1 : 0);
    return (sn > 0) ? mc : -mc;
  endfunction

  function automatic hsi_t convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    hsi_t        res;
    int          r, g, b, s, mn, da, db, num, q, cnt, deg;
    logic [63:0] num2;
    logic [63:0] den4;
    r = r8; g = g8; b = b8;
    s = r + g + b;
    res = '0;
    res.inten = ChanW'(s / 3);
    if (s / 3 > 0 && !(r == g && g == b)) begin
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      res.sat = ChanW'((255 * (s - 3 * mn)) / s);
      da   = r - g;
      db   = r - b;
      num  = 2 * r - g - b;
      q    = da * da + db * db - da * db;
      num2 = 64'(num * num) << 44;
      den4 = 64'(4 * q);
      cnt  = 0;
      if (g >= b) begin
        for (int k = 1; k <= 180; k++) if (cos_order(num, num2, den4, k) <= 0) cnt++;
        deg = cnt;
      end else begin
        for (int k = 0; k < 180; k++) if (cos_order(num, num2, den4, k) < 0) cnt++;
        deg = 360 - cnt;
      end
      res.hue = ChanW'(deg / 2);
    end
    return res;
  endfunction

  // send one pixel, with a random idle burst before it when enabled
  // valid stays high after the item so the next one can follow back to back
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_hsi.push_back(convert_pixel(r, g, b));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_hsi.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_corners();
    send_pixel(8'd0, 8'd0, 8'd0);       // dark
    send_pixel(8'd1, 8'd0, 8'd1);       // dark, not grey
    send_pixel(8'd2, 8'd0, 8'd1);       // smallest lit sum
    send_pixel(8'd255, 8'd255, 8'd255); // grey at full scale
    send_pixel(8'd77, 8'd77, 8'd77);    // grey
    send_pixel(8'd255, 8'd0, 8'd0);     // pure red
    send_pixel(8'd0, 8'd255, 8'd0);     // exact 120 degrees
    send_pixel(8'd0, 8'd0, 8'd255);     // exact 240 degrees
    send_pixel(8'd255, 8'd255, 8'd0);   // 60
    send_pixel(8'd0, 8'd255, 8'd255);   // 180
    send_pixel(8'd255, 8'd0, 8'd255);   // 300
    send_pixel(8'd255, 8'd0, 8'd1);     // just below 360
    send_pixel(8'd255, 8'd1, 8'd0);     // just above 0
    send_pixel(8'd170, 8'd85, 8'd255);
    send_pixel(8'd85, 8'd170, 8'd255);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd128, 8'd127, 8'd129);
  endtask

  // the sender holds off until the pipe is empty, then sends random pixels with idle bursts
  task automatic test_drain_pause();
    wait_drained();
    for (int i = 0; i < 30; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_random(int count);
    logic [7:0] base;
    for (int i = 0; i < count; i++) begin
      base = 8'($urandom);
      case ($urandom_range(0, 3))
        0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        // near grey, many small angle cases
        1: send_pixel(base, base + 8'($urandom_range(0, 2)), base - 8'($urandom_range(0, 2)));
        // dark or almost dark
        2: send_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                      8'($urandom_range(0, 3)));
        // one channel at an extreme
        default: send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0, 8'($urandom),
                            8'($urandom));
      endcase
    end
  endtask

  // output side: random stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (rx_idle_en && !out_stall_i && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      fork
        begin
          repeat ($urandom_range(1, 9)) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      join_none
    end
  end

  // result check against the oldest expected pixel
  always @(posedge clk_i) begin
    hsi_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hsi.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: hue %0d sat %0d int %0d",
                                       hue_half_degrees_o, saturation_level_o,
                                       intensity_level_o);
      end else begin
        want = pending_hsi.pop_front();
        if (want.hue !== hue_half_degrees_o || want.sat !== saturation_level_o ||
            want.inten !== intensity_level_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hue %0d sat %0d int %0d, got hue %0d sat %0d int %0d",
                     want.hue, want.sat, want.inten, hue_half_degrees_o,
                     saturation_level_o, intensity_level_o);
        end
      end
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (pending_hsi.size() == 0 && !in_valid_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) timed_out <= 1'b1;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    red_i      = '0;
    green_i    = '0;
    blue_i     = '0;
    mismatches = 0;
    idle_cycles = 0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    timed_out  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_drain_pause();
    test_random(750);
    // final stretch at full rate
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(150);
    wait_drained();
    repeat (Latency + 5) @(posedge clk_i);
    if (mismatches == 0 && pending_hsi.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("TEST FAILED");
    $finish;
  end

endmodule
